[hw/rtl/fsqrt_pkg.sv]
// Shared constants and helper functions for the approximate square root datapath.
`default_nettype none

package fsqrt_pkg;

  localparam logic [31:0] MagicGuess = 32'h5F3759DF;
  localparam logic [31:0] FpHalf     = 32'h3F000000;
  localparam logic [31:0] FpOneHalf  = 32'h3FC00000;
  localparam logic [31:0] CanonNan   = 32'h7FC00000;
  localparam logic [7:0]  ExpAllOnes = 8'hFF;

  // Leading zero count of a 24-bit mantissa; an all-zero value gives 24.
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Leading zero count of a 27-bit sum; an all-zero value gives 27.
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd27;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 5'(26 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack. The exponent is at least one; a mantissa
  // without its leading bit set is a subnormal and packs with a zero exponent.
  function automatic logic [31:0] fp_round(input logic s, input logic [9:0] e,
                                           input logic [23:0] m, input logic g,
                                           input logic st);
    logic        inc;
    logic [24:0] r;
    logic [9:0]  ex;
    logic [31:0] res;
    inc = g & (st | m[0]);
    r   = {1'b0, m} + 25'(inc);
    if (r[24]) begin
      ex = e + 10'd1;
    end else if (r[23]) begin
      ex = e;
    end else begin
      ex = '0;
    end
    if (ex >= 10'd255) begin
      res = {s, ExpAllOnes, 23'd0};
    end else begin
      res = {s, ex[7:0], (r[24] ? 23'd0 : r[22:0])};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fast_approx_square_root_unit.sv]
// Top level of the pipelined approximate square root unit.
// Throughput: one beat per cycle while the output is not stalled; the
// chain of five multipliers and one subtractor, five and six register
// stages each, sets the depth.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and a stalled output still lets new beats in.
// Reset (rst_ni low, asynchronous) clears only the stage valid bits.
`default_nettype none

module fast_approx_square_root_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // [31:0] operand_bits
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // [31:0] root_bits
);
  import fsqrt_pkg::*;

  // Stage map: half = x * 0.5 in stages 0-4, t = half * y in 5-9,
  // t = t * y in 10-14, t = 1.5 - t in 15-20, y = y * t in 21-25 and
  // the result x * y in 26-30. The last stage register drives the output.
  localparam int unsigned NumStg = 31;
  localparam int unsigned XLen   = 26;
  localparam int unsigned YLen   = 21;

  logic [NumStg-1:0] valid_q;
  logic [NumStg-1:0] adv;

  // Each stage may load when it is empty or its contents move on.
  assign adv[NumStg-1] = !valid_q[NumStg-1] || m_axis_tready_i;
  for (genvar k = 0; k < NumStg - 1; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // The operand x and the estimate y ride along beside the arithmetic.
  logic [31:0] x_q [XLen];
  logic [31:0] y_q [YLen];
  logic [31:0] guess;

  // Initial estimate of 1/sqrt(x): the magic constant minus the operand bits
  // shifted right arithmetically by one, wrapping modulo 2^32.
  assign guess = MagicGuess - {s_axis_tdata_i[31], s_axis_tdata_i[31:1]};

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      x_q[0] <= s_axis_tdata_i;
      y_q[0] <= guess;
    end
    for (int k = 1; k < XLen; k++) begin
      if (adv[k]) begin
        x_q[k] <= x_q[k-1];
      end
    end
    for (int k = 1; k < YLen; k++) begin
      if (adv[k]) begin
        y_q[k] <= y_q[k-1];
      end
    end
  end

  logic [31:0] half, t1, t2, t3, y2, root;

  fsqrt_mul u_half (
    .clk_i (clk_i),
    .en_i  (adv[4:0]),
    .a_i   (s_axis_tdata_i),
    .b_i   (FpHalf),
    .res_o (half)
  );

  fsqrt_mul u_t1 (
    .clk_i (clk_i),
    .en_i  (adv[9:5]),
    .a_i   (half),
    .b_i   (y_q[4]),
    .res_o (t1)
  );

  fsqrt_mul u_t2 (
    .clk_i (clk_i),
    .en_i  (adv[14:10]),
    .a_i   (t1),
    .b_i   (y_q[9]),
    .res_o (t2)
  );

  fsqrt_sub u_t3 (
    .clk_i (clk_i),
    .en_i  (adv[20:15]),
    .a_i   (FpOneHalf),
    .b_i   (t2),
    .res_o (t3)
  );

  fsqrt_mul u_y2 (
    .clk_i (clk_i),
    .en_i  (adv[25:21]),
    .a_i   (y_q[20]),
    .b_i   (t3),
    .res_o (y2)
  );

  // Final product; NaN results come out of the multiplier already canonical.
  fsqrt_mul u_root (
    .clk_i (clk_i),
    .en_i  (adv[30:26]),
    .a_i   (x_q[25]),
    .b_i   (y2),
    .res_o (root)
  );

  assign s_axis_tready_o = adv[0];
  assign m_axis_tvalid_o = valid_q[NumStg-1];
  assign m_axis_tdata_o  = root;

endmodule

`default_nettype wire

[hw/rtl/fsqrt_mul.sv]
// Five-stage single-precision multiplier with round to nearest even.
`default_nettype none

module fsqrt_mul (
  input  wire logic        clk_i,
  input  wire logic [4:0]  en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      res_o
);
  import fsqrt_pkg::*;

  // Stage 0: unpack, special cases and leading zero counts.
  logic        s0_s_q, s0_nan_q, s0_inf_q, s0_zero_q;
  logic [7:0]  s0_ea_q, s0_eb_q;
  logic [23:0] s0_ma_q, s0_mb_q;
  logic [4:0]  s0_la_q, s0_lb_q;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma_d, mb_d;

  always_comb begin
    a_nan  = (a_i[30:23] == ExpAllOnes) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == ExpAllOnes) && (b_i[22:0] != '0);
    a_inf  = (a_i[30:23] == ExpAllOnes) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == ExpAllOnes) && (b_i[22:0] == '0);
    a_zero = (a_i[30:0] == '0);
    b_zero = (b_i[30:0] == '0);
    ma_d   = {(a_i[30:23] != '0), a_i[22:0]};
    mb_d   = {(b_i[30:23] != '0), b_i[22:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_s_q    <= a_i[31] ^ b_i[31];
      s0_nan_q  <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
      s0_inf_q  <= a_inf | b_inf;
      s0_zero_q <= a_zero | b_zero;
      s0_ea_q   <= (a_i[30:23] == '0) ? 8'd1 : a_i[30:23];
      s0_eb_q   <= (b_i[30:23] == '0) ? 8'd1 : b_i[30:23];
      s0_ma_q   <= ma_d;
      s0_mb_q   <= mb_d;
      s0_la_q   <= lzc24(ma_d);
      s0_lb_q   <= lzc24(mb_d);
    end
  end

  // Stage 1: normalize both mantissas and form the product exponent.
  logic              s1_s_q, s1_nan_q, s1_inf_q, s1_zero_q;
  logic signed [9:0] s1_e_q;
  logic [23:0]       s1_ma_q, s1_mb_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_s_q    <= s0_s_q;
      s1_nan_q  <= s0_nan_q;
      s1_inf_q  <= s0_inf_q;
      s1_zero_q <= s0_zero_q;
      s1_ma_q   <= s0_ma_q << s0_la_q;
      s1_mb_q   <= s0_mb_q << s0_lb_q;
      s1_e_q    <= $signed(10'(s0_ea_q)) - $signed(10'(s0_la_q))
                 + $signed(10'(s0_eb_q)) - $signed(10'(s0_lb_q)) - 10'sd127;
    end
  end

  // Stage 2: the mantissa product.
  logic              s2_s_q, s2_nan_q, s2_inf_q, s2_zero_q;
  logic signed [9:0] s2_e_q;
  logic [47:0]       s2_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_s_q    <= s1_s_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= s1_zero_q;
      s2_e_q    <= s1_e_q;
      s2_p_q    <= 48'(s1_ma_q) * 48'(s1_mb_q);
    end
  end

  // Stage 3: align the product, denormalizing with sticky when it underflows.
  logic              s3_s_q, s3_nan_q, s3_inf_q, s3_zero_q, s3_g_q, s3_st_q;
  logic [9:0]        s3_e_q;
  logic [23:0]       s3_m_q;

  logic [47:0]       pn, pq, pmask;
  logic signed [9:0] er, sh;
  logic [4:0]        shc;
  logic [9:0]        e3_d;
  logic [23:0]       m3_d;
  logic              g3_d, st3_d;

  always_comb begin
    pn    = s2_p_q[47] ? s2_p_q : (s2_p_q << 1);
    er    = s2_e_q + $signed(10'(s2_p_q[47]));
    sh    = 10'sd1 - er;
    shc   = (sh > 10'sd31) ? 5'd31 : sh[4:0];
    pq    = pn >> shc;
    pmask = (48'd1 << shc) - 48'd1;
    if (er >= 10'sd1) begin
      e3_d  = er;
      m3_d  = pn[47:24];
      g3_d  = pn[23];
      st3_d = |pn[22:0];
    end else begin
      e3_d  = 10'd1;
      m3_d  = pq[47:24];
      g3_d  = pq[23];
      st3_d = (|pq[22:0]) | (|(pn & pmask));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_s_q    <= s2_s_q;
      s3_nan_q  <= s2_nan_q;
      s3_inf_q  <= s2_inf_q;
      s3_zero_q <= s2_zero_q;
      s3_e_q    <= e3_d;
      s3_m_q    <= m3_d;
      s3_g_q    <= g3_d;
      s3_st_q   <= st3_d;
    end
  end

  // Stage 4: round, pack and substitute special results.
  logic [31:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      if (s3_nan_q) begin
        res_q <= CanonNan;
      end else if (s3_inf_q) begin
        res_q <= {s3_s_q, ExpAllOnes, 23'd0};
      end else if (s3_zero_q) begin
        res_q <= {s3_s_q, 31'd0};
      end else begin
        res_q <= fp_round(s3_s_q, s3_e_q, s3_m_q, s3_g_q, s3_st_q);
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/fsqrt_sub.sv]
// Six-stage single-precision subtractor (a minus b) with round to nearest even.
`default_nettype none

module fsqrt_sub (
  input  wire logic        clk_i,
  input  wire logic [5:0]  en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      res_o
);
  import fsqrt_pkg::*;

  // Stage 0: unpack, negate b, order the operands by magnitude.
  logic        s0_sl_q, s0_sub_q, s0_nan_q, s0_inf_q, s0_is_q;
  logic [7:0]  s0_el_q, s0_es_q;
  logic [23:0] s0_ml_q, s0_ms_q;

  logic        a_nan, b_nan, a_inf, b_inf, nb_s, a_big;
  logic [31:0] big, sml;

  always_comb begin
    nb_s  = ~b_i[31];
    a_nan = (a_i[30:23] == ExpAllOnes) && (a_i[22:0] != '0);
    b_nan = (b_i[30:23] == ExpAllOnes) && (b_i[22:0] != '0);
    a_inf = (a_i[30:23] == ExpAllOnes) && (a_i[22:0] == '0);
    b_inf = (b_i[30:23] == ExpAllOnes) && (b_i[22:0] == '0);
    a_big = (a_i[30:0] >= b_i[30:0]);
    big   = a_big ? a_i : {nb_s, b_i[30:0]};
    sml   = a_big ? {nb_s, b_i[30:0]} : a_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s0_sl_q  <= big[31];
      s0_sub_q <= a_i[31] ^ nb_s;
      s0_nan_q <= a_nan | b_nan | (a_inf & b_inf & (a_i[31] != nb_s));
      s0_inf_q <= a_inf | b_inf;
      s0_is_q  <= a_inf ? a_i[31] : nb_s;
      s0_el_q  <= (big[30:23] == '0) ? 8'd1 : big[30:23];
      s0_es_q  <= (sml[30:23] == '0) ? 8'd1 : sml[30:23];
      s0_ml_q  <= {(big[30:23] != '0), big[22:0]};
      s0_ms_q  <= {(sml[30:23] != '0), sml[22:0]};
    end
  end

  // Stage 1: align the smaller operand with guard, round and sticky bits.
  logic        s1_sl_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_is_q;
  logic [7:0]  s1_el_q;
  logic [26:0] s1_ml_q, s1_ms_q;

  logic [7:0]  d;
  logic [4:0]  shc;
  logic [26:0] msx, msh, mmask;

  always_comb begin
    d     = s0_el_q - s0_es_q;
    shc   = (d > 8'd27) ? 5'd27 : d[4:0];
    msx   = {s0_ms_q, 3'b000};
    msh   = msx >> shc;
    mmask = (27'd1 << shc) - 27'd1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_sl_q  <= s0_sl_q;
      s1_sub_q <= s0_sub_q;
      s1_nan_q <= s0_nan_q;
      s1_inf_q <= s0_inf_q;
      s1_is_q  <= s0_is_q;
      s1_el_q  <= s0_el_q;
      s1_ml_q  <= {s0_ml_q, 3'b000};
      s1_ms_q  <= {msh[26:1], msh[0] | (|(msx & mmask))};
    end
  end

  // Stage 2: add or subtract the magnitudes.
  logic        s2_sl_q, s2_sub_q, s2_nan_q, s2_inf_q, s2_is_q;
  logic [7:0]  s2_el_q;
  logic [27:0] s2_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s2_sl_q  <= s1_sl_q;
      s2_sub_q <= s1_sub_q;
      s2_nan_q <= s1_nan_q;
      s2_inf_q <= s1_inf_q;
      s2_is_q  <= s1_is_q;
      s2_el_q  <= s1_el_q;
      s2_sum_q <= s1_sub_q ? ({1'b0, s1_ml_q} - {1'b0, s1_ms_q})
                           : ({1'b0, s1_ml_q} + {1'b0, s1_ms_q});
    end
  end

  // Stage 3: leading zero count of the sum.
  logic        s3_sl_q, s3_sub_q, s3_nan_q, s3_inf_q, s3_is_q;
  logic [7:0]  s3_el_q;
  logic [27:0] s3_sum_q;
  logic [4:0]  s3_lz_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s3_sl_q  <= s2_sl_q;
      s3_sub_q <= s2_sub_q;
      s3_nan_q <= s2_nan_q;
      s3_inf_q <= s2_inf_q;
      s3_is_q  <= s2_is_q;
      s3_el_q  <= s2_el_q;
      s3_sum_q <= s2_sum_q;
      s3_lz_q  <= lzc27(s2_sum_q[26:0]);
    end
  end

  // Stage 4: normalize, stopping at the smallest normal exponent.
  logic        s4_s_q, s4_nan_q, s4_inf_q, s4_is_q, s4_zero_q, s4_g_q, s4_st_q;
  logic [9:0]  s4_e_q;
  logic [23:0] s4_m_q;

  logic [7:0]  emax;
  logic [4:0]  shn;
  logic [26:0] nrm;
  logic [9:0]  e4_d;
  logic [23:0] m4_d;
  logic        g4_d, st4_d;

  always_comb begin
    emax = s3_el_q - 8'd1;
    shn  = (8'(s3_lz_q) > emax) ? emax[4:0] : s3_lz_q;
    nrm  = s3_sum_q[26:0] << shn;
    if (s3_sum_q[27]) begin
      e4_d  = 10'(s3_el_q) + 10'd1;
      m4_d  = s3_sum_q[27:4];
      g4_d  = s3_sum_q[3];
      st4_d = |s3_sum_q[2:0];
    end else begin
      e4_d  = 10'(s3_el_q) - 10'(shn);
      m4_d  = nrm[26:3];
      g4_d  = nrm[2];
      st4_d = |nrm[1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      // An exact cancellation gives positive zero.
      s4_s_q    <= (s3_sum_q == '0 && s3_sub_q) ? 1'b0 : s3_sl_q;
      s4_nan_q  <= s3_nan_q;
      s4_inf_q  <= s3_inf_q;
      s4_is_q   <= s3_is_q;
      s4_zero_q <= (s3_sum_q == '0);
      s4_e_q    <= e4_d;
      s4_m_q    <= m4_d;
      s4_g_q    <= g4_d;
      s4_st_q   <= st4_d;
    end
  end

  // Stage 5: round, pack and substitute special results.
  logic [31:0] res_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      if (s4_nan_q) begin
        res_q <= CanonNan;
      end else if (s4_inf_q) begin
        res_q <= {s4_is_q, ExpAllOnes, 23'd0};
      end else if (s4_zero_q) begin
        res_q <= {s4_s_q, 31'd0};
      end else begin
        res_q <= fp_round(s4_s_q, s4_e_q, s4_m_q, s4_g_q, s4_st_q);
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[hw/rtl/fsqrt_chk.sv]
// Port-level checker for the approximate square root unit, with its bind.
`default_nettype none

module fsqrt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o
);

  // No output beat is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // With an empty output stage the whole pipeline can move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output stage");

  // Every NaN result carries the canonical quiet pattern.
  a_canon_nan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[30:23] == 8'hFF && m_axis_tdata_o[22:0] != 23'd0)
    |-> m_axis_tdata_o == 32'h7FC00000)
    else $error("non-canonical NaN on output");

  // A stalled output beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled output beat changed");

endmodule

bind fast_approx_square_root_unit fsqrt_chk u_fsqrt_chk (.*);

`default_nettype wire
